/* rtl/ring_buffer_fir_filter_unit_assert.svh */
// Assertion macros shared by the ring buffer FIR filter RTL.
// Depends on nothing; files that assert include it by name and must have clk and rst in scope.
`ifndef RING_BUFFER_FIR_FILTER_UNIT_ASSERT_SVH
`define RING_BUFFER_FIR_FILTER_UNIT_ASSERT_SVH
`ifndef SYNTH
// A condition that holds at every clock edge outside reset.
`define RBFF_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// A trigger that implies a consequence in the next cycle.
`define RBFF_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);
`else
`define RBFF_ASSERT_ALWAYS(lbl, cond, msg)
`define RBFF_ASSERT_NEXT(lbl, trig, cons, msg)
`endif
`endif

/* rtl/rbff_pkg.sv */
// Package of the ring buffer FIR filter: field widths, request kinds and control structs.
// Depends on nothing.
package rbff_pkg;

  localparam int DATA_W     = 16;
  localparam int IDX_W      = 5;
  localparam int CFG_W      = 6;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int FRAC_W     = 15;
  localparam int TAPS_RESET = 32;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_COEF   = 1'b1;

  // Per-cell control of the sample and coefficient chain.
  typedef struct packed {
    logic active;   // cell lies inside the rotating region
    logic wrap;     // last cell of the region, takes from the head
    logic shift_s;  // rotate the sample chain
    logic shift_c;  // rotate the coefficient chain
    logic load_s;   // write a new sample into this cell
    logic load_c;   // write a new coefficient into this cell
  } cell_ctl_t;

  // Control of the shared multiply-accumulate unit.
  typedef struct packed {
    logic clear;
    logic run;
  } mac_ctl_t;

endpackage

/* rtl/rbff_cell.sv */
// One cell of the ring buffer FIR chain: one sample slot and one coefficient slot.
// Depends on rbff_pkg.
module rbff_cell (
  input  logic                                  clk,
  input  logic                                  rst,
  input  rbff_pkg::cell_ctl_t                   ctl,
  input  logic signed [rbff_pkg::DATA_W-1:0]    load_value,
  input  logic signed [rbff_pkg::DATA_W-1:0]    neighbor_sample,
  input  logic signed [rbff_pkg::DATA_W-1:0]    head_sample,
  input  logic signed [rbff_pkg::DATA_W-1:0]    neighbor_coef,
  input  logic signed [rbff_pkg::DATA_W-1:0]    head_coef,
  output logic signed [rbff_pkg::DATA_W-1:0]    sample,
  output logic signed [rbff_pkg::DATA_W-1:0]    coef
);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample <= '0;
      coef   <= '0;
    end else begin
      if (ctl.load_s) begin
        sample <= load_value;
      end else if (ctl.shift_s && ctl.active) begin
        sample <= ctl.wrap ? head_sample : neighbor_sample;
      end
      if (ctl.load_c) begin
        coef <= load_value;
      end else if (ctl.shift_c && ctl.active) begin
        coef <= ctl.wrap ? head_coef : neighbor_coef;
      end
    end
  end

endmodule

/* rtl/rbff_mac.sv */
// Shared multiply-accumulate of the ring buffer FIR filter, with the final shift and saturation.
// Depends on rbff_pkg.
module rbff_mac #(
  parameter int MAX_TAPS = 32
) (
  input  logic                                  clk,
  input  rbff_pkg::mac_ctl_t                    ctl,
  input  logic signed [rbff_pkg::DATA_W-1:0]    sample,
  input  logic signed [rbff_pkg::DATA_W-1:0]    coef,
  output logic signed [rbff_pkg::DATA_W-1:0]    result
);

  localparam int ACC_W = rbff_pkg::PROD_W + $clog2(MAX_TAPS);
  localparam int Q_W   = ACC_W - rbff_pkg::FRAC_W;
  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(32767);
  localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(-32768);

  logic signed [rbff_pkg::PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]            acc;
  logic signed [Q_W-1:0]              quot;

  // The product is registered before it enters the accumulator.
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      prod <= '0;
      acc  <= '0;
    end else if (ctl.run) begin
      prod <= sample * coef;
      acc  <= acc + ACC_W'(prod);
    end
  end

  // Arithmetic shift rounds toward minus infinity.
  assign quot = Q_W'(acc >>> rbff_pkg::FRAC_W);

  always_comb begin
    if (quot > Q_MAX) begin
      result = rbff_pkg::DATA_W'(Q_MAX);
    end else if (quot < Q_MIN) begin
      result = rbff_pkg::DATA_W'(Q_MIN);
    end else begin
      result = rbff_pkg::DATA_W'(quot);
    end
  end

endmodule

/* rtl/ring_buffer_fir_filter_unit.sv */
// Top level of the ring buffer FIR filter: control sequencer, cell chain and output register.
// Depends on rbff_pkg, rbff_cell, rbff_mac and ring_buffer_fir_filter_unit_assert.svh.
//
//   channel   handshake                  payload
//   item      item_valid/item_stall      kind, sample_value, coef_index
//   result    result_valid/result_stall  filtered_value
//   cfg       cfg_valid/cfg_ready        tap_count
//
// A sample request passes through T MAC steps, a drain and a finish, T being the effective tap
// count; the finish waits while a stalled result holds the output register, then the next request
// can be taken. A coefficient load keeps the sequencer idle; a tap count write may realign the chain.
// Reset clears every sample and coefficient cell, the position and sets the tap count to 32.
// A stalled result waits in the output register while the next request is being filtered.
module ring_buffer_fir_filter_unit #(
  parameter int MAX_TAPS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  logic                                  kind,
  input  logic signed [rbff_pkg::DATA_W-1:0]    sample_value,
  input  logic        [rbff_pkg::IDX_W-1:0]     coef_index,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic signed [rbff_pkg::DATA_W-1:0]    filtered_value,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic        [rbff_pkg::CFG_W-1:0]     tap_count
);

`include "ring_buffer_fir_filter_unit_assert.svh"

  localparam int CNT_W = $clog2(MAX_TAPS + 1);
  localparam int POS_W = $clog2(MAX_TAPS);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MAC   = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_FIN   = 5'b01000,
    ST_ALIGN = 5'b10000
  } state_t;

  state_t                     state;
  logic [rbff_pkg::CFG_W-1:0] taps_reg;
  logic [CNT_W-1:0]           rot_taps;
  logic [POS_W-1:0]           pos;
  logic [POS_W-1:0]           step;

  logic [31:0]                taps_ext;
  logic [31:0]                eff_ext;
  logic [CNT_W-1:0]           eff;
  logic [CNT_W-1:0]           region;
  logic                       item_take;
  logic                       smp_take;
  logic                       cfg_take;
  logic                       fin_take;
  logic                       pos_wraps;
  logic                       step_last;
  logic                       out_free;

  logic signed [rbff_pkg::DATA_W-1:0] smp [MAX_TAPS];
  logic signed [rbff_pkg::DATA_W-1:0] cf  [MAX_TAPS];
  rbff_pkg::cell_ctl_t                ctl [MAX_TAPS];
  rbff_pkg::mac_ctl_t                 mac_ctl;
  logic signed [rbff_pkg::DATA_W-1:0] mac_result;

  // Effective tap count: zero acts as one, anything above the chain length is clamped.
  assign taps_ext = 32'(taps_reg);
  always_comb begin
    if (taps_ext == 32'd0) begin
      eff_ext = 32'd1;
    end else if (taps_ext > 32'(MAX_TAPS)) begin
      eff_ext = 32'(MAX_TAPS);
    end else begin
      eff_ext = taps_ext;
    end
  end
  assign eff = CNT_W'(eff_ext);

  // While realigning after a tap count write, the chain still rotates over the old region.
  assign region = (state == ST_ALIGN) ? rot_taps : eff;

  assign item_stall = (state != ST_IDLE);
  assign item_take  = item_valid && !item_stall;
  assign smp_take   = item_take && (kind == rbff_pkg::KIND_SAMPLE);
  // A tap count write gives way to a request offered in the same cycle.
  assign cfg_ready  = (state == ST_IDLE) && !item_valid;
  assign cfg_take   = cfg_valid && cfg_ready;
  assign out_free   = !result_valid || !result_stall;
  assign fin_take   = (state == ST_FIN) && out_free;

  assign pos_wraps = (32'(pos) + 32'd1) >= 32'(region);
  assign step_last = 32'(step) == (32'(region) - 32'd1);

  // The chain keeps ring slot (pos + i) mod T in cell i, so cell 0 is the write position
  // and coefficient i always lines up with cell i. One full rotation of both chains feeds
  // every pair past the MAC and restores them; one more sample shift advances the position.
  for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
    assign ctl[i] = '{
      active:  (32'(i) < 32'(region)),
      wrap:    (32'(i) == (32'(region) - 32'd1)),
      shift_s: (state == ST_MAC) || (state == ST_DRAIN) || (state == ST_ALIGN),
      shift_c: (state == ST_MAC),
      load_s:  (i == 0) && smp_take,
      load_c:  item_take && (kind == rbff_pkg::KIND_COEF) && (32'(coef_index) == 32'(i))
    };

    rbff_cell u_cell (
      .clk             (clk),
      .rst             (rst),
      .ctl             (ctl[i]),
      .load_value      (sample_value),
      .neighbor_sample (smp[(i + 1) % MAX_TAPS]),
      .head_sample     (smp[0]),
      .neighbor_coef   (cf[(i + 1) % MAX_TAPS]),
      .head_coef       (cf[0]),
      .sample          (smp[i]),
      .coef            (cf[i])
    );
  end

  // The MAC runs through the rotation and through the drain state, which adds the last product.
  assign mac_ctl = '{
    clear: smp_take,
    run:   (state == ST_MAC) || (state == ST_DRAIN)
  };

  rbff_mac #(
    .MAX_TAPS (MAX_TAPS)
  ) u_mac (
    .clk    (clk),
    .ctl    (mac_ctl),
    .sample (smp[0]),
    .coef   (cf[0]),
    .result (mac_result)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      taps_reg <= rbff_pkg::CFG_W'(rbff_pkg::TAPS_RESET);
      rot_taps <= '0;
      pos      <= '0;
      step     <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (smp_take) begin
            step  <= '0;
            state <= ST_MAC;
          end else if (cfg_take) begin
            taps_reg <= tap_count;
            rot_taps <= eff;
            if (pos != '0) begin
              state <= ST_ALIGN;
            end
          end
        end
        ST_MAC: begin
          step <= step + 1'b1;
          if (step_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          pos   <= pos_wraps ? '0 : pos + 1'b1;
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        ST_ALIGN: begin
          // Rotate the old region until ring slot 0 sits in cell 0 again.
          if (pos_wraps) begin
            pos   <= '0;
            state <= ST_IDLE;
          end else begin
            pos <= pos + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register: a finished result waits here while the next request proceeds.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fin_take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_take) begin
      filtered_value <= mac_result;
    end
  end

  `RBFF_ASSERT_ALWAYS(a_pos_in_region, 32'(pos) < 32'(region), "position outside region")
  `RBFF_ASSERT_NEXT(a_sample_starts, smp_take, state == ST_MAC, "sample did not start the MAC")
  `RBFF_ASSERT_NEXT(a_cfg_realign, cfg_take, (state == ST_ALIGN) || (pos == '0), "misaligned")
  `RBFF_ASSERT_NEXT(a_fin_delivers, fin_take, result_valid && (state == ST_IDLE), "result lost")
  `RBFF_ASSERT_ALWAYS(a_step_bound, (state != ST_MAC) || (32'(step) < 32'(region)), "step overrun")

endmodule

/* bench/ring_buffer_fir_filter_unit_test.sv */
// Self-checking testbench of ring_buffer_fir_filter_unit: directed and random requests,
// checked against a behavioral filter model kept inside the bench.
// Depends on rbff_pkg and the ring_buffer_fir_filter_unit RTL.
module ring_buffer_fir_filter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   DATA_W      = rbff_pkg::DATA_W;
  localparam int   IDX_W       = rbff_pkg::IDX_W;
  localparam int   CFG_W       = rbff_pkg::CFG_W;
  localparam int   FRAC_W      = rbff_pkg::FRAC_W;
  localparam int   TAPS_RESET  = rbff_pkg::TAPS_RESET;
  localparam logic KIND_SAMPLE = rbff_pkg::KIND_SAMPLE;
  localparam logic KIND_COEF   = rbff_pkg::KIND_COEF;

  localparam int MAX_TAPS = 32;
  // Quiet cycles after the last expected result before a tap count write or the end.
  // Covers a trailing coefficient load and a full chain realignment.
  localparam int SETTLE_CYCLES = 80;
  // Cycles in a row without any accepted request before the run is called hung.
  localparam int WATCHDOG_LIMIT = 5000;
  // Length of the long receiver hold-off that fills the block.
  localparam int LONG_HOLD_CYCLES = 600;

  logic                       clk;
  logic                       rst;
  logic                       item_valid;
  logic                       item_stall;
  logic                       kind;
  logic signed [DATA_W-1:0]   sample_value;
  logic        [IDX_W-1:0]    coef_index;
  logic                       result_valid;
  logic                       result_stall;
  logic signed [DATA_W-1:0]   filtered_value;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic        [CFG_W-1:0]    tap_count;

  // Model state: sample ring, coefficient slots, ring position and the tap count register.
  logic signed [DATA_W-1:0]   ring_samples [MAX_TAPS];
  logic signed [DATA_W-1:0]   coef_slots [MAX_TAPS];
  int unsigned                ring_pos;
  logic        [CFG_W-1:0]    taps_setting;

  // Filter outputs still owed by the block, oldest first.
  logic signed [DATA_W-1:0]   pending_outputs [$];

  int unsigned error_count;
  int unsigned idle_run;

  // Idle controls shared by the stimulus tasks and the result sink.
  bit          source_idles;
  bit          sink_idles;
  int unsigned hold_off_cycles;

  ring_buffer_fir_filter_unit #(
    .MAX_TAPS(MAX_TAPS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .kind          (kind),
    .sample_value  (sample_value),
    .coef_index    (coef_index),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .filtered_value(filtered_value),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .tap_count     (tap_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Writes the new sample at the ring position, forms the weighted sum over the active
  // taps, advances the position and returns the shifted, saturated output.
  function automatic logic signed [DATA_W-1:0] filter_sample(input logic signed [DATA_W-1:0] v);
    int unsigned taps;
    int unsigned pos;
    int unsigned j;
    logic signed [47:0] acc;
    logic signed [47:0] q;
    // A tap count of zero behaves as one, anything above the chain length as the full chain.
    if (taps_setting < 1) taps = 1;
    else if (taps_setting > MAX_TAPS) taps = MAX_TAPS;
    else taps = 32'(taps_setting);
    pos = (ring_pos >= taps) ? 0 : ring_pos;
    ring_samples[pos] = v;
    acc = '0;
    j = pos;
    for (int k = 0; k < taps; k++) begin
      acc += coef_slots[k] * ring_samples[j];
      j++;
      if (j >= taps) j = 0;
    end
    pos++;
    if (pos >= taps) pos = 0;
    ring_pos = pos;
    // The arithmetic shift rounds toward minus infinity; then clamp to 16 signed bits.
    q = acc >>> FRAC_W;
    if (q > 32767) return 16'sh7FFF;
    if (q < -32768) return -16'sh8000;
    return q[DATA_W-1:0];
  endfunction

  // Mostly random words, with a fair share of both extremes and small magnitudes.
  function automatic logic signed [DATA_W-1:0] random_word();
    int unsigned r;
    r = $urandom();
    case ($urandom_range(0, 7))
      0: return -16'sh8000;
      1: return 16'sh7FFF;
      2: return $signed(16'($urandom_range(0, 15))) - 16'sd8;
      default: return r[DATA_W-1:0];
    endcase
  endfunction

  // Offers one request, after a random gap when the source idles, and holds it until the block takes it.
  // The model is updated at the edge where the request is accepted.
  task automatic send_request(input logic req_kind, input logic signed [DATA_W-1:0] value,
                              input logic [IDX_W-1:0] slot);
    int unsigned gap;
    gap = source_idles ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      @(negedge clk);
      item_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    item_valid   <= 1'b1;
    kind         <= req_kind;
    sample_value <= value;
    coef_index   <= slot;
    do @(posedge clk); while (item_stall);
    if (req_kind == KIND_COEF) begin
      if (slot < MAX_TAPS) coef_slots[slot] = value;
    end else begin
      pending_outputs.push_back(filter_sample(value));
    end
  endtask

  // Drops the request valid and waits until every owed output has come out and the
  // block has had time to finish any trailing coefficient load.
  task automatic wait_drained();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Tap count writes happen only with the block idle; the position restarts at zero.
  task automatic write_tap_count(input logic [CFG_W-1:0] value);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    tap_count <= value;
    do @(posedge clk); while (!cfg_ready);
    taps_setting = value;
    ring_pos     = 0;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // After reset every coefficient is zero, so any sample must filter to zero.
  task automatic test_reset_state();
    source_idles = 1'b0;
    sink_idles   = 1'b0;
    send_request(KIND_SAMPLE, 16'sh7FFF, 5'd0);
    send_request(KIND_SAMPLE, -16'sh8000, 5'd31);
    send_request(KIND_SAMPLE, 16'sd0, 5'd0);
  endtask

  // Coefficient loads at both ends of the slot range and with alternating bit patterns.
  task automatic test_coef_loads();
    send_request(KIND_COEF, 16'sh7FFF, 5'd0);
    send_request(KIND_COEF, -16'sh8000, 5'd31);
    send_request(KIND_COEF, 16'sh5555, 5'd21);
    send_request(KIND_COEF, $signed(16'hAAAA), 5'd10);
    send_request(KIND_SAMPLE, 16'sd1, 5'd0);
    send_request(KIND_SAMPLE, -16'sd1, 5'd0);
  endtask

  // Two full-scale taps push the sum past both ends of the output range.
  task automatic test_saturation();
    write_tap_count(6'd2);
    send_request(KIND_COEF, 16'sh7FFF, 5'd0);
    send_request(KIND_COEF, 16'sh7FFF, 5'd1);
    send_request(KIND_SAMPLE, 16'sh7FFF, 5'd0);
    send_request(KIND_SAMPLE, 16'sh7FFF, 5'd0);
    send_request(KIND_SAMPLE, -16'sh8000, 5'd0);
    send_request(KIND_SAMPLE, -16'sh8000, 5'd0);
  endtask

  // A single tap shows the floor behavior of the shift on tiny negative sums, and the
  // one product that overflows on its own: minus one times minus one.
  task automatic test_floor_shift();
    write_tap_count(6'd1);
    send_request(KIND_COEF, 16'sd1, 5'd0);
    send_request(KIND_SAMPLE, -16'sd1, 5'd0);
    send_request(KIND_SAMPLE, 16'sd1, 5'd0);
    send_request(KIND_COEF, -16'sh8000, 5'd0);
    send_request(KIND_SAMPLE, -16'sh8000, 5'd0);
  endtask

  // Register values outside the useful range: zero acts as one tap, anything past the
  // chain length as the full chain.
  task automatic test_tap_extremes();
    write_tap_count(6'd0);
    send_request(KIND_SAMPLE, 16'sd100, 5'd0);
    write_tap_count(6'd63);
    send_request(KIND_SAMPLE, -16'sd5, 5'd0);
    write_tap_count(6'd33);
    send_request(KIND_SAMPLE, 16'sd77, 5'd0);
  endtask

  // Random phases at several tap counts, each with its own idle behavior on both sides.
  // Stale slots beyond a shrunken tap count come back into play when it grows again.
  task automatic test_random_traffic();
    logic [CFG_W-1:0] plan [9];
    logic             req_kind;
    plan = '{6'd1, 6'd2, 6'd32, 6'd0, 6'd63, 6'd5, 6'd17, 6'd3, 6'd31};
    plan[5] = 6'($urandom_range(1, 32));
    plan[6] = 6'($urandom_range(0, 63));
    for (int p = 0; p < 9; p++) begin
      write_tap_count(plan[p]);
      // Roughly one phase in four runs with no idling at all on a side.
      source_idles = ($urandom_range(0, 3) != 0);
      sink_idles   = ($urandom_range(0, 3) != 0);
      repeat (100) begin
        req_kind = ($urandom_range(0, 3) == 0) ? KIND_COEF : KIND_SAMPLE;
        send_request(req_kind, random_word(), 5'($urandom_range(0, 31)));
      end
    end
  endtask

  // The sink holds off for a long stretch while the source offers back-to-back samples,
  // so the output register and the chain fill up and the block must stall its input.
  task automatic test_backpressure();
    write_tap_count(6'd3);
    source_idles    = 1'b0;
    sink_idles      = 1'b0;
    hold_off_cycles = LONG_HOLD_CYCLES;
    repeat (30) send_request(KIND_SAMPLE, random_word(), 5'($urandom_range(0, 31)));
    wait_drained();
  endtask

  // Result sink: before each result it stalls a random number of cycles when the sink idles, or for the long
  // hold-off when one has been asked for, counted here in its own process.
  initial begin : result_sink
    int unsigned stall_cycles;
    result_stall = 1'b0;
    forever begin
      if (hold_off_cycles > 0) begin
        stall_cycles    = hold_off_cycles;
        hold_off_cycles = 0;
      end else if (sink_idles) begin
        stall_cycles = $urandom_range(0, 11);
      end else begin
        stall_cycles = 0;
      end
      if (stall_cycles > 0) begin
        @(negedge clk);
        result_stall <= 1'b1;
        repeat (stall_cycles - 1) @(negedge clk);
      end
      @(negedge clk);
      result_stall <= 1'b0;
      do @(posedge clk); while (!(result_valid && !result_stall));
    end
  end

  // Every accepted result is checked against the oldest owed output.
  always @(posedge clk) begin : result_check
    logic signed [DATA_W-1:0] want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_outputs.size() == 0) begin
        $error("unexpected result: filtered_value=%0d", filtered_value);
        error_count++;
      end else begin
        want = pending_outputs.pop_front();
        if (filtered_value !== want) begin
          $error("filtered_value: expected %0d, actual %0d", want, filtered_value);
          error_count++;
        end
      end
    end
  end

  // Watchdog: any accepted request on any channel restarts the count.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_run <= 0;
    end else if (idle_run >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  initial begin
    rst             = 1'b1;
    item_valid      = 1'b0;
    kind            = KIND_SAMPLE;
    sample_value    = '0;
    coef_index      = '0;
    cfg_valid       = 1'b0;
    tap_count       = '0;
    error_count     = 0;
    idle_run        = 0;
    source_idles    = 1'b0;
    sink_idles      = 1'b0;
    hold_off_cycles = 0;
    // Model state after reset: both stores clear, position zero, full chain in use.
    for (int i = 0; i < MAX_TAPS; i++) begin
      ring_samples[i] = '0;
      coef_slots[i]   = '0;
    end
    ring_pos     = 0;
    taps_setting = CFG_W'(TAPS_RESET);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_coef_loads();
    test_saturation();
    test_floor_shift();
    test_tap_extremes();
    test_random_traffic();
    test_backpressure();
    wait_drained();

    if (error_count == 0 && pending_outputs.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      if (pending_outputs.size() != 0) begin
        $error("%0d filter outputs never arrived", pending_outputs.size());
      end
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
